// ===== rtl/prts_pkg.sv =====
// Shared types and codes for the process table scheduler.
// Holds the request and response structs, entry encodings and the control states.
// No dependencies.
`timescale 1ns / 1ps

package prts_pkg;

  typedef enum logic [1:0] {
    PS_EMPTY   = 2'd0,
    PS_READY   = 2'd1,
    PS_RUNNING = 2'd2,
    PS_STOPPED = 2'd3
  } proc_state_t;

  // One table entry as it is kept in memory.
  typedef struct packed {
    proc_state_t state;
    logic [1:0]  flags;
  } entry_word_t;

  localparam logic [2:0] KIND_SCHEDULE = 3'd0;
  localparam logic [2:0] KIND_BLOCK    = 3'd1;
  localparam logic [2:0] KIND_UNBLOCK  = 3'd2;
  localparam logic [2:0] KIND_CREATE   = 3'd3;
  localparam logic [2:0] KIND_KILL     = 3'd4;

  localparam logic [1:0] PRIV_KERNEL = 2'd0;
  localparam logic [1:0] PRIV_USER   = 2'd1;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] process_id;
    logic [1:0] flag_mask;
    logic [1:0] privilege;
  } request_t;

  typedef struct packed {
    logic [3:0] selected_id;
    logic       ok;
    logic       switched;
  } response_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MODIFY,
    S_SCHED_RD,
    S_SCHED,
    S_STOP,
    S_RESP
  } sched_state_t;

endpackage

// ===== rtl/prts_table.sv =====
// Task table storage: one synchronous memory of entry words with a registered read.
// Per-entry valid, empty and eligible bits in flip-flops summarize the table.
// Depends on prts_pkg.
`timescale 1ns / 1ps

module prts_table import prts_pkg::*; #(
  parameter int NUM_ENTRIES = 16,
  localparam int IW = $clog2(NUM_ENTRIES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IW-1:0]          rd_addr,
  output entry_word_t            rd_word,
  input  logic                   wr_en,
  input  logic [IW-1:0]          wr_addr,
  input  entry_word_t            wr_word,
  output logic [NUM_ENTRIES-1:0] empty_vec,
  output logic [NUM_ENTRIES-1:0] elig_vec
);

  entry_word_t            mem [NUM_ENTRIES];
  entry_word_t            rd_raw;
  logic                   rd_valid;
  logic [NUM_ENTRIES-1:0] valid;

  function automatic logic is_eligible(entry_word_t w);
    return (w.flags == 2'b00) && (w.state == PS_READY || w.state == PS_STOPPED);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_raw <= mem[rd_addr];
  end

  // An entry never written since reset reads as empty with no flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      empty_vec <= '1;
      elig_vec  <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      if (wr_en) begin
        valid[wr_addr]     <= 1'b1;
        empty_vec[wr_addr] <= (wr_word.state == PS_EMPTY);
        elig_vec[wr_addr]  <= is_eligible(wr_word);
      end
    end
  end

  assign rd_word = rd_valid ? rd_raw : entry_word_t'{state: PS_EMPTY, flags: 2'b00};

endmodule

// ===== rtl/process_table_round_robin_scheduler.sv =====
// Top level of the round-robin process table scheduler.
// Control sequencer, slot and pick searches; the table lives in prts_table.
// Depends on prts_pkg and prts_table.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------
//   request | req_valid | req_stall | req (request_t)
//   result  | rsp_valid | rsp_stall | rsp (response_t)
//
// One request is in flight at a time. Create and unknown kinds go from S_IDLE to
// S_RESP; unblock and kill pass S_MODIFY, schedule S_SCHED, block S_MODIFY,
// S_SCHED_RD and S_SCHED (S_MODIFY only for a valid id), as read-modify-write
// passes on the single memory port. Stopping the old running entry adds S_STOP.
// Reset clears the table at once through valid bits; no clearing pass is needed.
// A stalled result holds in the output register and the sequencer waits for it.
`timescale 1ns / 1ps

module process_table_round_robin_scheduler import prts_pkg::*; #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  request_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output response_t rsp
);

  localparam int IW = $clog2(NUM_ENTRIES);

  sched_state_t state, state_next;

  logic [IW-1:0] cur;
  logic [IW-1:0] prev_q;
  logic [1:0]    hold_flags;
  request_t      req_q;
  response_t     res;

  logic [IW-1:0]          rd_addr;
  entry_word_t            rd_word;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  entry_word_t            wr_word;
  logic [NUM_ENTRIES-1:0] empty_vec;
  logic [NUM_ENTRIES-1:0] elig_vec;

  logic          pid_ok_in, pid_ok_q, priv_ok, rsp_free, req_accept;
  logic [IW-1:0] pid_idx_in, pid_idx_q;
  entry_word_t   mod_word;

  logic          free_found;
  logic [IW-1:0] free_idx;

  logic [IW:0]              shift_amt;
  logic [2*NUM_ENTRIES-1:0] rot;
  logic [NUM_ENTRIES-1:0]   window;
  logic                     pick_found;
  logic [IW-1:0]            pick_off;
  logic [IW:0]              pick_sum;
  logic [IW-1:0]            pick_idx;

  prts_table #(.NUM_ENTRIES(NUM_ENTRIES)) u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .rd_word   (rd_word),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_word   (wr_word),
    .empty_vec (empty_vec),
    .elig_vec  (elig_vec)
  );

  assign req_accept = req_valid && !req_stall;
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign pid_ok_in  = int'(req.process_id) < NUM_ENTRIES;
  assign pid_ok_q   = int'(req_q.process_id) < NUM_ENTRIES;
  assign pid_idx_in = IW'(req.process_id);
  assign pid_idx_q  = IW'(req_q.process_id);
  assign priv_ok    = (req.privilege == PRIV_KERNEL) || (req.privilege == PRIV_USER);

  // Lowest empty slot for create.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (!free_found && empty_vec[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // Round-robin pick: rotate the eligible bits so the entry after the current
  // one lands at position zero; the current entry itself comes last.
  always_comb begin
    shift_amt  = {1'b0, cur} + (IW+1)'(1);
    rot        = {elig_vec, elig_vec} >> shift_amt;
    window     = rot[NUM_ENTRIES-1:0];
    pick_found = 1'b0;
    pick_off   = '0;
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      if (!pick_found && window[k]) begin
        pick_found = 1'b1;
        pick_off   = IW'(k);
      end
    end
    pick_sum = shift_amt + {1'b0, pick_off};
    if (int'(pick_sum) >= NUM_ENTRIES) begin
      pick_idx = IW'(pick_sum - (IW+1)'(NUM_ENTRIES));
    end else begin
      pick_idx = IW'(pick_sum);
    end
  end

  always_comb begin
    mod_word = rd_word;
    case (req_q.kind)
      KIND_BLOCK:   mod_word.flags = rd_word.flags | req_q.flag_mask;
      KIND_UNBLOCK: mod_word.flags = rd_word.flags & ~req_q.flag_mask;
      KIND_KILL:    mod_word.state = PS_EMPTY;
      default:      mod_word = rd_word;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req.kind) inside
            KIND_SCHEDULE:          state_next = S_SCHED;
            KIND_BLOCK:             state_next = pid_ok_in ? S_MODIFY : S_SCHED_RD;
            KIND_UNBLOCK, KIND_KILL: state_next = pid_ok_in ? S_MODIFY : S_RESP;
            default:                state_next = S_RESP;
          endcase
        end
      end
      S_MODIFY:   state_next = (req_q.kind == KIND_BLOCK) ? S_SCHED_RD : S_RESP;
      S_SCHED_RD: state_next = S_SCHED;
      S_SCHED: begin
        if (pick_found && pick_idx != cur && rd_word.state == PS_RUNNING) begin
          state_next = S_STOP;
        end else begin
          state_next = S_RESP;
        end
      end
      S_STOP: state_next = S_RESP;
      S_RESP: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port control and request stall.
  always_comb begin
    req_stall = (state != S_IDLE);
    rd_addr   = cur;
    wr_en     = 1'b0;
    wr_addr   = pid_idx_q;
    wr_word   = mod_word;
    unique case (state)
      S_IDLE: begin
        rd_addr = (req.kind == KIND_SCHEDULE) ? cur : pid_idx_in;
        if (req_valid && req.kind == KIND_CREATE && priv_ok && free_found) begin
          wr_en   = 1'b1;
          wr_addr = free_idx;
          wr_word = entry_word_t'{state: PS_READY, flags: 2'b00};
        end
      end
      S_MODIFY: begin
        wr_en = 1'b1;
      end
      S_SCHED_RD: begin
        rd_addr = cur;
      end
      S_SCHED: begin
        if (pick_found) begin
          wr_en   = 1'b1;
          wr_addr = pick_idx;
          wr_word = entry_word_t'{state: PS_RUNNING, flags: 2'b00};
        end
      end
      S_STOP: begin
        wr_en   = 1'b1;
        wr_addr = prev_q;
        wr_word = entry_word_t'{state: PS_STOPPED, flags: hold_flags};
      end
      S_RESP: begin
        rd_addr = cur;
      end
      default: begin
        rd_addr = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCHED && pick_found) begin
        cur <= pick_idx;
      end
      if (state == S_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q        <= req;
      res.switched <= 1'b0;
      if (req.kind == KIND_CREATE) begin
        res.selected_id <= (priv_ok && free_found) ? 4'(free_idx) : 4'd0;
        res.ok          <= priv_ok && free_found;
      end else begin
        res.selected_id <= req.process_id;
        res.ok          <= 1'b0;
      end
    end
    if (state == S_MODIFY) begin
      res.ok <= 1'b1;
    end
    if (state == S_SCHED) begin
      prev_q          <= cur;
      hold_flags      <= rd_word.flags;
      res.selected_id <= 4'(pick_found ? pick_idx : cur);
      res.ok          <= (req_q.kind == KIND_SCHEDULE) || pid_ok_q;
      res.switched    <= pick_found && (pick_idx != cur);
    end
    if (state == S_RESP && rsp_free) begin
      rsp <= res;
    end
  end

  // A scheduling write always names the entry that becomes current.
  a_pick_becomes_current: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCHED && wr_en) |=> (cur == $past(wr_addr)))
    else $error("scheduled entry did not become current");

  // The stop write must never land on the entry that was just made running.
  a_stop_not_current: assert property (@(posedge clk) disable iff (rst)
    (state == S_STOP) |-> (prev_q != cur))
    else $error("stop write targets the new current entry");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> (state != S_IDLE))
    else $error("accepted request did not start the sequencer");

endmodule
